// ===== rtl/texture_page_rect_splitter_assert.svh =====
// Assertion macros for the texture page rectangle splitter.
// Included by the top level; no other dependencies.
`ifndef TEXTURE_PAGE_RECT_SPLITTER_ASSERT_SVH
`define TEXTURE_PAGE_RECT_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define TPRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("texture_page_rect_splitter: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define TPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("texture_page_rect_splitter: next-cycle check failed");
`else
`define TPRS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tprs_pkg.sv =====
// Shared types and constants of the texture page rectangle splitter.
// Used by every module of the block except tprs_fifo; depends on nothing.
package tprs_pkg;

    localparam int PAGE_LOG2_DEFAULT = 8;
    localparam int MAX_TILES         = 18;
    localparam int COUNT_W           = $clog2(MAX_TILES + 1);
    localparam int JOB_DEPTH         = 2;
    localparam int OUT_DEPTH         = 2;

    typedef struct packed {
        logic [11:0] start_x;
        logic [8:0]  start_y;
        logic [9:0]  rect_width;
        logic [8:0]  rect_height;
    } rect_t;

    typedef struct packed {
        logic [12:0] adjusted_x;
        logic [9:0]  adjusted_y;
        logic [4:0]  page_col;
        logic [2:0]  page_row;
        logic [7:0]  in_page_x;
        logic [7:0]  in_page_y;
        logic [9:0]  src_x;
        logic [8:0]  src_y;
        logic [7:0]  tile_width;
        logic [7:0]  tile_height;
        logic        last_tile;
    } tile_t;

    // A classified, non-empty rectangle with its start already bumped.
    typedef struct packed {
        logic [12:0] adj_x;
        logic [9:0]  adj_y;
        logic [9:0]  width;
        logic [8:0]  height;
    } job_t;

    typedef struct packed {
        logic job_pop;
        logic tile_push;
        logic busy;
    } walk_ctl_t;

endpackage

// ===== rtl/tprs_fifo.sv =====
// Small register FIFO used for the job queue and the result queue.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module tprs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW + 1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/tprs_front.sv =====
// Front end: accepts rectangles, bumps all-ones start coordinates into the
// next page and drops empty rectangles. Depends on tprs_pkg.
module tprs_front import tprs_pkg::*; #(
    parameter int PAGE_LOG2 = PAGE_LOG2_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  rect_t rect,
    output job_t  job,
    output logic  job_push,
    input  logic  job_full
);

    logic        valid_reg, valid_next;
    job_t        job_reg;
    logic        accept, nonempty;
    logic [9:0]  y_ext;
    logic [12:0] adj_x;
    logic [9:0]  adj_y;

    assign full     = valid_reg && job_full;
    assign accept   = push && !full;
    assign nonempty = (rect.rect_width != '0) && (rect.rect_height != '0);
    assign y_ext    = {1'b0, rect.start_y};
    assign adj_x    = {1'b0, rect.start_x} + 13'(&rect.start_x[PAGE_LOG2-1:0]);
    assign adj_y    = y_ext + 10'(&y_ext[PAGE_LOG2-1:0]);
    assign job      = job_reg;
    assign job_push = valid_reg && !job_full;

    // Accepting implies the held job is leaving or absent.
    assign valid_next = (accept && nonempty) || (valid_reg && job_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg.adj_x  <= adj_x;
            job_reg.adj_y  <= adj_y;
            job_reg.width  <= rect.rect_width;
            job_reg.height <= rect.rect_height;
        end
    end

endmodule

// ===== rtl/tprs_walker.sv =====
// Back end: walks one job column-major and emits one tile per cycle while the result queue has room.
// Depends on tprs_pkg.
module tprs_walker import tprs_pkg::*; #(
    parameter int PAGE_LOG2 = PAGE_LOG2_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      job,
    input  logic      job_empty,
    input  logic      out_full,
    output tile_t     tile,
    output walk_ctl_t ctl
);

    localparam int CW = (PAGE_LOG2 > 10) ? PAGE_LOG2 : 10;
    localparam int RW = (PAGE_LOG2 > 9) ? PAGE_LOG2 : 9;

    typedef enum logic {ST_IDLE, ST_WALK} state_t;

    state_t               state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [PAGE_LOG2-1:0] col_off_reg, col_off_next;
    logic [9:0]           col_rem_reg, col_rem_next;
    logic [4:0]           col_page_reg, col_page_next;
    logic [PAGE_LOG2-1:0] row_off_reg, row_off_next;
    logic [8:0]           row_rem_reg, row_rem_next;
    logic [2:0]           row_page_reg, row_page_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic [PAGE_LOG2-1:0] col_room, row_room;
    logic [CW-1:0]        cw;
    logic [RW-1:0]        ch;
    logic                 col_done, row_done, cap, last, load, emit;

    always_comb
    begin
        col_room = ~col_off_reg;
        row_room = ~row_off_reg;
        cw = (CW'(col_room) > CW'(col_rem_reg)) ? CW'(col_rem_reg) : CW'(col_room);
        ch = (RW'(row_room) > RW'(row_rem_reg)) ? RW'(row_rem_reg) : RW'(row_room);
        col_done = (CW'(col_rem_reg) == cw);
        row_done = (RW'(row_rem_reg) == ch);
        cap      = (count_reg == COUNT_W'(MAX_TILES - 1));
        last     = cap || (col_done && row_done);
        load     = (state_reg == ST_IDLE) && !job_empty;
        emit     = (state_reg == ST_WALK) && !out_full;
    end

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        col_off_next  = col_off_reg;
        col_rem_next  = col_rem_reg;
        col_page_next = col_page_reg;
        row_off_next  = row_off_reg;
        row_rem_next  = row_rem_reg;
        row_page_next = row_page_reg;
        count_next    = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next    = ST_WALK;
                    job_next      = job;
                    col_off_next  = job.adj_x[PAGE_LOG2-1:0];
                    col_rem_next  = job.width;
                    col_page_next = 5'(job.adj_x >> PAGE_LOG2);
                    row_off_next  = job.adj_y[PAGE_LOG2-1:0];
                    row_rem_next  = job.height;
                    row_page_next = 3'(job.adj_y >> PAGE_LOG2);
                    count_next    = '0;
                end
            end
            ST_WALK:
            begin
                if (emit)
                begin
                    count_next = count_reg + 1'b1;
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (row_done)
                    begin
                        // Column finished: step to the next page column and
                        // restart the rows at the rectangle's top.
                        col_off_next  = '0;
                        col_rem_next  = col_rem_reg - 10'(cw);
                        col_page_next = col_page_reg + 1'b1;
                        row_off_next  = job_reg.adj_y[PAGE_LOG2-1:0];
                        row_rem_next  = job_reg.height;
                        row_page_next = 3'(job_reg.adj_y >> PAGE_LOG2);
                    end
                    else
                    begin
                        row_off_next  = '0;
                        row_rem_next  = row_rem_reg - 9'(ch);
                        row_page_next = row_page_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            job_reg      <= '0;
            col_off_reg  <= '0;
            col_rem_reg  <= '0;
            col_page_reg <= '0;
            row_off_reg  <= '0;
            row_rem_reg  <= '0;
            row_page_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            job_reg      <= job_next;
            col_off_reg  <= col_off_next;
            col_rem_reg  <= col_rem_next;
            col_page_reg <= col_page_next;
            row_off_reg  <= row_off_next;
            row_rem_reg  <= row_rem_next;
            row_page_reg <= row_page_next;
            count_reg    <= count_next;
        end
    end

    always_comb
    begin
        tile.adjusted_x  = job_reg.adj_x;
        tile.adjusted_y  = job_reg.adj_y;
        tile.page_col    = col_page_reg;
        tile.page_row    = row_page_reg;
        tile.in_page_x   = 8'(col_off_reg);
        tile.in_page_y   = 8'(row_off_reg);
        tile.src_x       = job_reg.width - col_rem_reg;
        tile.src_y       = job_reg.height - row_rem_reg;
        tile.tile_width  = 8'(cw);
        tile.tile_height = 8'(ch);
        tile.last_tile   = last;
        ctl.job_pop      = load;
        ctl.tile_push    = emit;
        ctl.busy         = (state_reg == ST_WALK);
    end

endmodule

// ===== rtl/texture_page_rect_splitter.sv =====
// Top level of the texture page rectangle splitter.
// Depends on tprs_pkg, tprs_fifo, tprs_front, tprs_walker and the assertion header.
//
// Usage: a rectangle request (start x/y, width, height) is written with push
// while full is low. Each rectangle is cut into tiles that stay inside one
// page and are at most one less than a page on a side; a start coordinate
// whose in-page part is all ones is first moved into the next page. Tiles come
// out column by column, top to bottom within a column, through a queue-style
// port: while empty is low the oldest tile is on the tile port, and pop takes
// it. The final tile of a rectangle carries last_tile. Empty rectangles are
// swallowed by the front end and give no tiles. At most 18 tiles per rectangle.
// A rectangle passes the front register, the job queue, the walker and the
// result queue before its first tile is visible. The walker loads a rectangle
// while idle, then emits one tile per cycle as long as the result queue has room.
// A two-entry job queue between front end and walker lets new rectangles be
// taken while the walker is busy. When the receiver stops popping, the result
// queue fills, the walker holds its position, and full rises once the job
// queue and front register are occupied. Reset clears all queues and the walk.

`include "texture_page_rect_splitter_assert.svh"

module texture_page_rect_splitter import tprs_pkg::*; #(
    parameter int PAGE_LOG2 = PAGE_LOG2_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  rect_t rect,
    output logic  empty,
    input  logic  pop,
    output tile_t tile
);

    job_t      front_job;
    logic      job_push, job_full;
    job_t      job_head;
    logic      job_empty;
    tile_t     walk_tile;
    logic      out_full;
    walk_ctl_t ctl;

    // Front end: classification and the all-ones bump.
    tprs_front #(
        .PAGE_LOG2 (PAGE_LOG2)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .rect     (rect),
        .job      (front_job),
        .job_push (job_push),
        .job_full (job_full)
    );

    // Job queue decoupling the front end from the walker.
    tprs_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (front_job),
        .full  (job_full),
        .pop   (ctl.job_pop),
        .rdata (job_head),
        .empty (job_empty)
    );

    // Walker: one tile per cycle while the result queue has room.
    tprs_walker #(
        .PAGE_LOG2 (PAGE_LOG2)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_head),
        .job_empty (job_empty),
        .out_full  (out_full),
        .tile      (walk_tile),
        .ctl       (ctl)
    );

    // Result queue; its registers separate the walker from the receiver.
    tprs_fifo #(
        .WIDTH ($bits(tile_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ctl.tile_push),
        .wdata (walk_tile),
        .full  (out_full),
        .pop   (pop),
        .rdata (tile),
        .empty (empty)
    );

    // The walker only emits into a result queue with room.
    `TPRS_ASSERT_SAME(a_tile_room, clk, rst_n, ctl.tile_push, !out_full)
    // The last tile of a rectangle ends the walk.
    `TPRS_ASSERT_NEXT(a_last_ends, clk, rst_n, ctl.tile_push && walk_tile.last_tile, !ctl.busy)
    // Empty rectangles never reach the job queue.
    `TPRS_ASSERT_SAME(a_job_nonempty, clk, rst_n, job_push,
        front_job.width != '0 && front_job.height != '0)

endmodule
